[src/sky_rph_pkg.sv]
`default_nettype none

package sky_rph_pkg;

    localparam int MAX_PIXELS   = 8192;
    localparam int MAX_RED_BINS = 8;

    localparam int CNT_DEPTH = MAX_PIXELS * MAX_RED_BINS;
    localparam int PIX_W     = $clog2(MAX_PIXELS);
    localparam int CNT_AW    = $clog2(CNT_DEPTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QAW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    localparam int CTH_W  = 17;
    localparam int PHI_W  = 16;
    localparam int Z_W    = 32;
    localparam int WT_W   = 16;
    localparam int PIXF_W = 13;
    localparam int BINF_W = 3;
    localparam int CNT_W  = 32;
    localparam int OCC_W  = 14;
    localparam int SC_W   = 7;
    localparam int SP_W   = 8;
    localparam int NB_W   = 4;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 32;

    typedef enum logic [0:0] {
        OP_ADD  = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [CFG_IW-1:0] {
        CFG_SIDE_CTH    = 3'd0,
        CFG_SIDE_PHI    = 3'd1,
        CFG_RED_BINS    = 3'd2,
        CFG_RED_ORIGIN  = 3'd3,
        CFG_RED_SCALE   = 3'd4,
        CFG_USE_WEIGHTS = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_op               op;
        logic              hit;
        logic              acc;
        logic              bad;
        logic [PIXF_W-1:0] pix_field;
        logic [BINF_W-1:0] bin_field;
        logic [PIX_W-1:0]  addr_pix;
        logic [CNT_AW-1:0] addr_bin;
        logic [WT_W-1:0]   add;
        logic              last;
    } t_task;

    typedef struct packed {
        logic [PIXF_W-1:0] pixel_index;
        logic [BINF_W-1:0] red_bin;
        logic              accepted;
        logic              bad_angle;
        logic [CNT_W-1:0]  bin_count;
        logic [CNT_W-1:0]  pixel_count;
        logic [OCC_W-1:0]  occupied_pixels;
        logic              last_out;
    } t_result;

endpackage

`default_nettype wire

[src/sky_rph_if.sv]
`default_nettype none

interface sky_rph_in_if;
    logic                                       valid;
    logic                                       ready;
    logic                                       op;
    logic signed [sky_rph_pkg::CTH_W-1:0]       cos_theta;
    logic        [sky_rph_pkg::PHI_W-1:0]       phi_turn;
    logic        [sky_rph_pkg::Z_W-1:0]         redshift;
    logic        [sky_rph_pkg::WT_W-1:0]        weight;
    logic        [sky_rph_pkg::PIXF_W-1:0]      read_pixel;
    logic        [sky_rph_pkg::BINF_W-1:0]      read_bin;
    logic                                       is_last;

    modport source (
        output valid, op, cos_theta, phi_turn, redshift, weight, read_pixel, read_bin,
               is_last,
        input  ready
    );
    modport sink (
        input  valid, op, cos_theta, phi_turn, redshift, weight, read_pixel, read_bin,
               is_last,
        output ready
    );
endinterface

interface sky_rph_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [sky_rph_pkg::PIXF_W-1:0]        pixel_index;
    logic [sky_rph_pkg::BINF_W-1:0]        red_bin;
    logic                                  accepted;
    logic                                  bad_angle;
    logic [sky_rph_pkg::CNT_W-1:0]         bin_count;
    logic [sky_rph_pkg::CNT_W-1:0]         pixel_count;
    logic [sky_rph_pkg::OCC_W-1:0]         occupied_pixels;
    logic                                  last_out;

    modport source (
        output valid, pixel_index, red_bin, accepted, bad_angle, bin_count, pixel_count,
               occupied_pixels, last_out,
        input  ready
    );
    modport sink (
        input  valid, pixel_index, red_bin, accepted, bad_angle, bin_count, pixel_count,
               occupied_pixels, last_out,
        output ready
    );
endinterface

interface sky_rph_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [sky_rph_pkg::CFG_IW-1:0]     index;
    logic [sky_rph_pkg::CFG_DW-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/sky_rph_ram.sv]
`default_nettype none

module sky_rph_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire              i_clk,
    input  wire              i_we,
    input  wire  [AW-1:0]    i_waddr,
    input  wire  [WIDTH-1:0] i_wdata,
    input  wire              i_re,
    input  wire  [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/sky_rph_front.sv]
`default_nettype none

module sky_rph_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_hold,
    sky_rph_in_if.sink              i_in,
    sky_rph_cfg_if.sink             i_cfg,
    output logic                    o_task_valid,
    input  wire                     i_task_ready,
    output sky_rph_pkg::t_task      o_task
);

    logic [sky_rph_pkg::SC_W-1:0]   r_side_cth;
    logic [sky_rph_pkg::SP_W-1:0]   r_side_phi;
    logic [sky_rph_pkg::NB_W-1:0]   r_red_bins;
    logic [sky_rph_pkg::Z_W-1:0]    r_red_origin;
    logic [sky_rph_pkg::Z_W-1:0]    r_red_scale;
    logic                           r_use_weights;

    logic                           r_s1_valid;
    sky_rph_pkg::t_op               r_s1_op;
    logic [2*sky_rph_pkg::Z_W-1:0]  r_s1_prod;
    logic                           r_s1_zge;
    logic [sky_rph_pkg::SC_W-1:0]   r_s1_row;
    logic [sky_rph_pkg::SP_W-1:0]   r_s1_col;
    logic                           r_s1_bad;
    logic [sky_rph_pkg::WT_W-1:0]   r_s1_add;
    logic [sky_rph_pkg::PIXF_W-1:0] r_s1_rpix;
    logic [sky_rph_pkg::BINF_W-1:0] r_s1_rbin;
    logic                           r_s1_last;

    logic                           r_s2_valid;
    sky_rph_pkg::t_task             r_s2_task;

    logic                           n_s1_valid;
    logic                           n_s2_valid;

    logic [sky_rph_pkg::SC_W-1:0]   sc;
    logic [sky_rph_pkg::SP_W-1:0]   sp;
    logic [sky_rph_pkg::NB_W-1:0]   nb;
    logic [15:0]                    c_off;
    logic [22:0]                    row_prod;
    logic [23:0]                    col_prod;
    logic                           is_top;
    logic                           bad;
    logic [sky_rph_pkg::Z_W-1:0]    z_diff;
    logic [35:0]                    iz_prod;
    logic [3:0]                     iz;
    logic                           bin_ok;
    logic [15:0]                    ipix;
    logic                           pix_ok;
    logic                           rd_ok;
    logic                           acc;
    logic                           accept;
    logic                           push;
    logic                           adv1;
    logic                           adv2;
    sky_rph_pkg::t_task             n_s2_task;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_cth    <= 7'd16;
            r_side_phi    <= 8'd32;
            r_red_bins    <= 4'd8;
            r_red_origin  <= 32'd0;
            r_red_scale   <= 32'd65536;
            r_use_weights <= 1'b0;
        end else if (i_cfg.valid) begin
            case (sky_rph_pkg::t_cfg_idx'(i_cfg.index))
                sky_rph_pkg::CFG_SIDE_CTH:    r_side_cth    <= i_cfg.data[6:0];
                sky_rph_pkg::CFG_SIDE_PHI:    r_side_phi    <= i_cfg.data[7:0];
                sky_rph_pkg::CFG_RED_BINS:    r_red_bins    <= i_cfg.data[3:0];
                sky_rph_pkg::CFG_RED_ORIGIN:  r_red_origin  <= i_cfg.data;
                sky_rph_pkg::CFG_RED_SCALE:   r_red_scale   <= i_cfg.data;
                sky_rph_pkg::CFG_USE_WEIGHTS: r_use_weights <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        sc = (r_side_cth == '0) ? 7'd1 : r_side_cth;
        sp = (r_side_phi == '0) ? 8'd1 : r_side_phi;
        nb = (32'(r_red_bins) > 32'(sky_rph_pkg::MAX_RED_BINS))
           ? 4'(sky_rph_pkg::MAX_RED_BINS) : r_red_bins;

        push   = r_s2_valid && i_task_ready;
        adv2   = !r_s2_valid || push;
        adv1   = !r_s1_valid || adv2;
        accept = i_in.valid && adv1 && !i_hold;

        c_off    = i_in.cos_theta[15:0] + 16'h8000;
        is_top   = (i_in.cos_theta == 17'sd32768);
        bad      = (i_in.cos_theta < -17'sd32768) || (i_in.cos_theta > 17'sd32768);
        row_prod = 23'(c_off) * 23'(sc);
        col_prod = 24'(i_in.phi_turn) * 24'(sp);
        z_diff   = i_in.redshift - r_red_origin;

        iz_prod = 36'(r_s1_prod[31:0]) * 36'(nb);
        iz      = iz_prod[35:32];
        bin_ok  = r_s1_zge && (nb != '0) && (r_s1_prod[63:32] == '0);
        ipix    = 16'(r_s1_row) * 16'(sp) + 16'(r_s1_col);
        pix_ok  = !r_s1_bad && (32'(ipix) < 32'(sky_rph_pkg::MAX_PIXELS));
        acc     = bin_ok && pix_ok;
        rd_ok   = (32'(r_s1_rpix) < 32'(sky_rph_pkg::MAX_PIXELS))
               && (32'(r_s1_rbin) < 32'(sky_rph_pkg::MAX_RED_BINS));

        n_s2_task.op   = r_s1_op;
        n_s2_task.add  = r_s1_add;
        n_s2_task.last = r_s1_last;
        if (r_s1_op == sky_rph_pkg::OP_READ) begin
            n_s2_task.hit       = rd_ok;
            n_s2_task.acc       = 1'b0;
            n_s2_task.bad       = 1'b0;
            n_s2_task.pix_field = r_s1_rpix;
            n_s2_task.bin_field = r_s1_rbin;
            n_s2_task.addr_pix  = sky_rph_pkg::PIX_W'(r_s1_rpix);
            n_s2_task.addr_bin  = sky_rph_pkg::CNT_AW'(
                32'(r_s1_rpix) * 32'(sky_rph_pkg::MAX_RED_BINS) + 32'(r_s1_rbin));
        end else begin
            n_s2_task.hit       = acc;
            n_s2_task.acc       = acc;
            n_s2_task.bad       = r_s1_bad;
            n_s2_task.pix_field = r_s1_bad ? '0 : ipix[sky_rph_pkg::PIXF_W-1:0];
            n_s2_task.bin_field = bin_ok ? iz[sky_rph_pkg::BINF_W-1:0] : '0;
            n_s2_task.addr_pix  = ipix[sky_rph_pkg::PIX_W-1:0];
            n_s2_task.addr_bin  = sky_rph_pkg::CNT_AW'(
                32'(ipix) * 32'(sky_rph_pkg::MAX_RED_BINS) + 32'(iz));
        end

        n_s1_valid = adv1 ? accept : r_s1_valid;
        n_s2_valid = adv2 ? r_s1_valid : r_s2_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op   <= sky_rph_pkg::t_op'(i_in.op);
            r_s1_prod <= 64'(z_diff) * 64'(r_red_scale);
            r_s1_zge  <= (i_in.redshift >= r_red_origin);
            r_s1_row  <= is_top ? (sc - 7'd1) : row_prod[22:16];
            r_s1_col  <= col_prod[23:16];
            r_s1_bad  <= bad;
            r_s1_add  <= r_use_weights ? i_in.weight : 16'd1;
            r_s1_rpix <= i_in.read_pixel;
            r_s1_rbin <= i_in.read_bin;
            r_s1_last <= i_in.is_last;
        end
        if (adv2) begin
            r_s2_task <= n_s2_task;
        end
    end

    assign i_in.ready   = adv1 && !i_hold;
    assign o_task_valid = r_s2_valid;
    assign o_task       = r_s2_task;

endmodule

`default_nettype wire

[src/sky_rph_fifo.sv]
`default_nettype none

module sky_rph_fifo (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push_valid,
    output logic                 o_push_ready,
    input  wire sky_rph_pkg::t_task i_push_data,
    output logic                 o_pop_valid,
    input  wire                  i_pop_ready,
    output sky_rph_pkg::t_task   o_pop_data
);

    sky_rph_pkg::t_task             r_mem [sky_rph_pkg::QUEUE_DEPTH];
    logic [sky_rph_pkg::QAW-1:0]    r_wptr;
    logic [sky_rph_pkg::QAW-1:0]    r_rptr;
    logic [sky_rph_pkg::QCW-1:0]    r_count;
    logic [sky_rph_pkg::QAW-1:0]    n_wptr;
    logic [sky_rph_pkg::QAW-1:0]    n_rptr;
    logic [sky_rph_pkg::QCW-1:0]    n_count;
    logic                           push;
    logic                           pop;

    localparam logic [sky_rph_pkg::QAW-1:0] LAST_PTR =
        sky_rph_pkg::QAW'(sky_rph_pkg::QUEUE_DEPTH - 1);

    always_comb begin
        o_push_ready = (r_count != sky_rph_pkg::QCW'(sky_rph_pkg::QUEUE_DEPTH));
        o_pop_valid  = (r_count != '0);
        push         = i_push_valid && o_push_ready;
        pop          = i_pop_ready && o_pop_valid;
        n_wptr       = r_wptr;
        n_rptr       = r_rptr;
        n_count      = r_count;
        if (push) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    assign o_pop_data = r_mem[r_rptr];

endmodule

`default_nettype wire

[src/sky_rph_back.sv]
`default_nettype none

module sky_rph_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_task_valid,
    output logic                    o_task_ready,
    input  wire sky_rph_pkg::t_task i_task,
    output logic                    o_clearing,
    sky_rph_out_if.source           o_out
);

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_LOOK  = 3'b100
    } t_bstate;

    localparam int PW_W = sky_rph_pkg::CNT_W + 1;

    t_bstate                          r_state;
    t_bstate                          n_state;
    logic [sky_rph_pkg::CNT_AW-1:0]   r_clr;
    logic [sky_rph_pkg::CNT_AW-1:0]   n_clr;
    logic [sky_rph_pkg::OCC_W-1:0]    r_occ;
    logic [sky_rph_pkg::OCC_W-1:0]    n_occ;
    logic                             r_ovalid;
    logic                             n_ovalid;
    sky_rph_pkg::t_task               r_task;
    sky_rph_pkg::t_result             r_res;
    sky_rph_pkg::t_result             n_res;

    logic                             out_free;
    logic                             pop;
    logic                             commit;
    logic                             counted;
    logic                             clearing;
    logic                             clr_pix;
    logic [sky_rph_pkg::CNT_W-1:0]    bin_rd;
    logic [PW_W-1:0]                  pix_rd;
    logic [sky_rph_pkg::CNT_W:0]      bin_sum;
    logic [sky_rph_pkg::CNT_W:0]      pix_sum;
    logic [sky_rph_pkg::CNT_W-1:0]    bin_new;
    logic [sky_rph_pkg::CNT_W-1:0]    pix_new;

    logic                             bin_we;
    logic [sky_rph_pkg::CNT_AW-1:0]   bin_waddr;
    logic [sky_rph_pkg::CNT_W-1:0]    bin_wdata;
    logic                             pix_we;
    logic [sky_rph_pkg::PIX_W-1:0]    pix_waddr;
    logic [PW_W-1:0]                  pix_wdata;

    always_comb begin
        clearing = (r_state == B_CLEAR);
        clr_pix  = ({1'b0, r_clr} < (sky_rph_pkg::CNT_AW + 1)'(sky_rph_pkg::MAX_PIXELS));
        out_free = !r_ovalid || o_out.ready;
        pop      = (r_state == B_IDLE) && i_task_valid;
        commit   = (r_state == B_LOOK) && out_free;
        counted  = (r_task.op == sky_rph_pkg::OP_ADD) && r_task.hit;

        bin_sum = {1'b0, bin_rd} + (sky_rph_pkg::CNT_W + 1)'(r_task.add);
        pix_sum = {1'b0, pix_rd[sky_rph_pkg::CNT_W-1:0]}
                + (sky_rph_pkg::CNT_W + 1)'(r_task.add);
        bin_new = bin_sum[sky_rph_pkg::CNT_W] ? '1 : bin_sum[sky_rph_pkg::CNT_W-1:0];
        pix_new = pix_sum[sky_rph_pkg::CNT_W] ? '1 : pix_sum[sky_rph_pkg::CNT_W-1:0];

        bin_we    = clearing || (commit && counted);
        bin_waddr = clearing ? r_clr : r_task.addr_bin;
        bin_wdata = clearing ? '0 : bin_new;
        pix_we    = clearing ? clr_pix : (commit && counted);
        pix_waddr = clearing ? r_clr[sky_rph_pkg::PIX_W-1:0] : r_task.addr_pix;
        pix_wdata = clearing ? '0 : {1'b1, pix_new};

        n_occ = r_occ;
        if (counted && !pix_rd[sky_rph_pkg::CNT_W] && (r_occ != '1)) begin
            n_occ = r_occ + 1'b1;
        end

        n_res.pixel_index     = r_task.pix_field;
        n_res.red_bin         = r_task.bin_field;
        n_res.accepted        = r_task.acc;
        n_res.bad_angle       = r_task.bad;
        n_res.occupied_pixels = n_occ;
        n_res.last_out        = r_task.last;
        if (!r_task.hit) begin
            n_res.bin_count   = '0;
            n_res.pixel_count = '0;
        end else if (counted) begin
            n_res.bin_count   = bin_new;
            n_res.pixel_count = pix_new;
        end else begin
            n_res.bin_count   = bin_rd;
            n_res.pixel_count = pix_rd[sky_rph_pkg::CNT_W-1:0];
        end

        n_state = r_state;
        n_clr   = r_clr;
        case (r_state)
            B_CLEAR: begin
                if (r_clr == sky_rph_pkg::CNT_AW'(sky_rph_pkg::CNT_DEPTH - 1)) begin
                    n_state = B_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            B_IDLE: begin
                if (pop) begin
                    n_state = B_LOOK;
                end
            end
            B_LOOK: begin
                if (commit) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_CLEAR;
                n_clr   = '0;
            end
        endcase

        n_ovalid = commit ? 1'b1 : (o_out.ready ? 1'b0 : r_ovalid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_CLEAR;
            r_clr    <= '0;
            r_occ    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
            if (commit) begin
                r_occ <= n_occ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_task <= i_task;
        end
        if (commit) begin
            r_res <= n_res;
        end
    end

    sky_rph_ram #(
        .WIDTH (sky_rph_pkg::CNT_W),
        .DEPTH (sky_rph_pkg::CNT_DEPTH)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (bin_we),
        .i_waddr (bin_waddr),
        .i_wdata (bin_wdata),
        .i_re    (pop),
        .i_raddr (i_task.addr_bin),
        .o_rdata (bin_rd)
    );

    sky_rph_ram #(
        .WIDTH (PW_W),
        .DEPTH (sky_rph_pkg::MAX_PIXELS)
    ) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_waddr),
        .i_wdata (pix_wdata),
        .i_re    (pop),
        .i_raddr (i_task.addr_pix),
        .o_rdata (pix_rd)
    );

    assign o_task_ready          = (r_state == B_IDLE);
    assign o_clearing            = clearing;
    assign o_out.valid           = r_ovalid;
    assign o_out.pixel_index     = r_res.pixel_index;
    assign o_out.red_bin         = r_res.red_bin;
    assign o_out.accepted        = r_res.accepted;
    assign o_out.bad_angle       = r_res.bad_angle;
    assign o_out.bin_count       = r_res.bin_count;
    assign o_out.pixel_count     = r_res.pixel_count;
    assign o_out.occupied_pixels = r_res.occupied_pixels;
    assign o_out.last_out        = r_res.last_out;

endmodule

`default_nettype wire

[src/sky_redshift_pixel_histogram.sv]
`default_nettype none

// Channel  | Dir | Port  | Carries
// ---------+-----+-------+-------------------------------------------------
// object   | in  | i_in  | op, cos_theta, phi_turn, redshift, weight, read_*
// result   | out | o_out | pixel_index, red_bin, flags, counts, occupancy
// config   | in  | i_cfg | index, data (always ready)
//
// Front pipeline: registers s1 and s2 between request and queue; one request
// per cycle while the queue has room and no clearing pass holds the input.
// Counter update: RAM read in B_IDLE, add and write in B_LOOK; no forwarding,
// so the next request waits for the write. Clearing after reset zeroes the
// counters with i_in.ready low; config writes are taken. A stalled result
// register holds the back end; the queue lets the front run on.

module sky_redshift_pixel_histogram (
    input  wire             i_clk,
    input  wire             i_rst_n,
    sky_rph_in_if.sink      i_in,
    sky_rph_out_if.source   o_out,
    sky_rph_cfg_if.sink     i_cfg
);

    logic                 front_valid;
    logic                 front_ready;
    sky_rph_pkg::t_task   front_task;
    logic                 q_valid;
    logic                 q_ready;
    sky_rph_pkg::t_task   q_task;
    logic                 clearing;

    sky_rph_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hold       (clearing),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .o_task_valid (front_valid),
        .i_task_ready (front_ready),
        .o_task       (front_task)
    );

    sky_rph_fifo u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_task),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_task)
    );

    sky_rph_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (q_valid),
        .o_task_ready (q_ready),
        .i_task       (q_task),
        .o_clearing   (clearing),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

[bench/sky_redshift_pixel_histogram_test.sv]
`default_nettype none

module sky_redshift_pixel_histogram_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sky_rph_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;
    localparam int OCC_SAT     = 16383;

    localparam logic [CFG_IW-1:0] CFG_UNMAPPED = 3'd6;

    typedef struct {
        t_op                     op;
        logic signed [CTH_W-1:0] cos_theta;
        logic [PHI_W-1:0]        phi_turn;
        logic [Z_W-1:0]          redshift;
        logic [WT_W-1:0]         weight;
        logic [PIXF_W-1:0]       read_pixel;
        logic [BINF_W-1:0]       read_bin;
        logic                    is_last;
    } t_catalog_req;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sky_rph_in_if  obj_ch ();
    sky_rph_out_if res_ch ();
    sky_rph_cfg_if cfg_ch ();

    sky_redshift_pixel_histogram dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (obj_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Mirror the histogram
    logic [CNT_W-1:0] bin_tally   [CNT_DEPTH];
    logic [CNT_W-1:0] pixel_tally [MAX_PIXELS];
    logic             pixel_seen  [MAX_PIXELS];
    int               occupied_total;

    logic [SC_W-1:0]  cfg_rows;
    logic [SP_W-1:0]  cfg_cols;
    logic [NB_W-1:0]  cfg_bins;
    logic [Z_W-1:0]   cfg_origin;
    logic [Z_W-1:0]   cfg_scale;
    logic             cfg_weighted;

    t_result          pending_results [$];
    logic [15:0]      recent_hits [$];
    t_result          oldest_result;

    int  mismatches;
    int  results_seen;
    int  cycles_run;
    bit  idling_enabled;
    int  hold_request;
    int  hold_left;
    int  stall_left;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles_run++;
        if (cycles_run == CYCLE_LIMIT) begin
            $display("sky_redshift_pixel_histogram_test: FAIL");
            $finish;
        end
    end

    function automatic logic [CNT_W-1:0] sat_sum(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + b;
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

    function automatic t_result predict_histogram(input t_catalog_req r);
        t_result     res;
        logic [31:0] sc, sp, nb, iz, ipix, icth, iphi, add;
        logic [63:0] prod;
        logic [CNT_AW-1:0] k;
        logic        bin_ok, pix_ok;
        int          cth;
        res = '0;
        res.last_out = r.is_last;
        if (r.op == OP_READ) begin
            res.pixel_index = r.read_pixel;
            res.red_bin     = r.read_bin;
            res.bin_count   = bin_tally[{r.read_pixel, r.read_bin}];
            res.pixel_count = pixel_tally[r.read_pixel];
        end else begin
            sc = (cfg_rows == 0) ? 32'd1 : 32'(cfg_rows);
            sp = (cfg_cols == 0) ? 32'd1 : 32'(cfg_cols);
            nb = (cfg_bins > MAX_RED_BINS) ? 32'(MAX_RED_BINS) : 32'(cfg_bins);
            bin_ok = 1'b0;
            pix_ok = 1'b0;
            iz = '0;
            ipix = '0;
            if (r.redshift >= cfg_origin && nb != 0) begin
                prod = 64'(r.redshift - cfg_origin) * 64'(cfg_scale);
                if (prod[63:32] == 0) begin
                    iz = 32'((prod * 64'(nb)) >> 32);
                    bin_ok = iz < nb;
                end
            end
            cth = int'(r.cos_theta);
            if (cth < -32768 || cth > 32768) begin
                res.bad_angle = 1'b1;
            end else begin
                if (cth == 32768)
                    icth = sc - 1;
                else
                    icth = (32'(cth + 32768) * sc) >> 16;
                iphi = (32'(r.phi_turn) * sp) >> 16;
                ipix = iphi + icth * sp;
                res.pixel_index = ipix[PIXF_W-1:0];
                pix_ok = ipix < MAX_PIXELS;
            end
            if (bin_ok)
                res.red_bin = iz[BINF_W-1:0];
            if (bin_ok && pix_ok) begin
                add = cfg_weighted ? 32'(r.weight) : 32'd1;
                k = {ipix[PIX_W-1:0], iz[BINF_W-1:0]};
                bin_tally[k] = sat_sum(bin_tally[k], add);
                pixel_tally[ipix[PIX_W-1:0]] = sat_sum(pixel_tally[ipix[PIX_W-1:0]], add);
                if (!pixel_seen[ipix[PIX_W-1:0]]) begin
                    pixel_seen[ipix[PIX_W-1:0]] = 1'b1;
                    if (occupied_total < OCC_SAT)
                        occupied_total++;
                end
                res.accepted    = 1'b1;
                res.bin_count   = bin_tally[k];
                res.pixel_count = pixel_tally[ipix[PIX_W-1:0]];
            end
        end
        res.occupied_pixels = OCC_W'(occupied_total);
        return res;
    endfunction

    task automatic send_req(input t_catalog_req r);
        t_result res;
        int      gap;
        if (idling_enabled && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            obj_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        obj_ch.valid      <= 1'b1;
        obj_ch.op         <= r.op;
        obj_ch.cos_theta  <= r.cos_theta;
        obj_ch.phi_turn   <= r.phi_turn;
        obj_ch.redshift   <= r.redshift;
        obj_ch.weight     <= r.weight;
        obj_ch.read_pixel <= r.read_pixel;
        obj_ch.read_bin   <= r.read_bin;
        obj_ch.is_last    <= r.is_last;
        do @(posedge i_clk); while (!obj_ch.ready);
        res = predict_histogram(r);
        pending_results.push_back(res);
        if (res.accepted) begin
            recent_hits.push_back({res.pixel_index, res.red_bin});
            if (recent_hits.size() > 32)
                void'(recent_hits.pop_front());
        end
    endtask

    task automatic send_object(input int cth, input logic [PHI_W-1:0] phi,
                               input logic [Z_W-1:0] z, input logic [WT_W-1:0] w,
                               input logic last);
        t_catalog_req r;
        r.op         = OP_ADD;
        r.cos_theta  = CTH_W'(cth);
        r.phi_turn   = phi;
        r.redshift   = z;
        r.weight     = w;
        r.read_pixel = PIXF_W'($urandom);
        r.read_bin   = BINF_W'($urandom);
        r.is_last    = last;
        send_req(r);
    endtask

    task automatic send_read(input logic [PIXF_W-1:0] pix, input logic [BINF_W-1:0] bin,
                             input logic last);
        t_catalog_req r;
        r.op         = OP_READ;
        r.cos_theta  = CTH_W'($urandom);
        r.phi_turn   = PHI_W'($urandom);
        r.redshift   = $urandom;
        r.weight     = WT_W'($urandom);
        r.read_pixel = pix;
        r.read_bin   = bin;
        r.is_last    = last;
        send_req(r);
    endtask

    task automatic drain_results();
        obj_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_SIDE_CTH:    cfg_rows     = data[SC_W-1:0];
            CFG_SIDE_PHI:    cfg_cols     = data[SP_W-1:0];
            CFG_RED_BINS:    cfg_bins     = data[NB_W-1:0];
            CFG_RED_ORIGIN:  cfg_origin   = data;
            CFG_RED_SCALE:   cfg_scale    = data;
            CFG_USE_WEIGHTS: cfg_weighted = data[0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Fill the unused upper bits of narrow registers with junk
    task automatic apply_settings(input int sc, input int sp, input int nb,
                                  input logic [Z_W-1:0] origin, input logic [Z_W-1:0] scale,
                                  input bit weights);
        logic [CFG_DW-1:0] junk;
        drain_results();
        junk = $urandom;
        cfg_write(CFG_SIDE_CTH, {junk[CFG_DW-1:SC_W], SC_W'(sc)});
        junk = $urandom;
        cfg_write(CFG_SIDE_PHI, {junk[CFG_DW-1:SP_W], SP_W'(sp)});
        junk = $urandom;
        cfg_write(CFG_RED_BINS, {junk[CFG_DW-1:NB_W], NB_W'(nb)});
        cfg_write(CFG_RED_ORIGIN, origin);
        cfg_write(CFG_RED_SCALE, scale);
        junk = $urandom;
        cfg_write(CFG_USE_WEIGHTS, {junk[CFG_DW-1:1], weights});
    endtask

    task automatic test_cleared_store();
        send_read('0, '0, 1'b0);
        send_read('1, '1, 1'b1);
        send_read(13'd123, 3'd5, 1'b0);
    endtask

    task automatic test_angle_edges();
        send_object(-32768, 16'h0000, 32'h0000_0000, 16'h0001, 1'b0);
        send_object(32768, 16'hFFFF, 32'h0000_FFFF, 16'h0002, 1'b0);
        send_object(32767, 16'h8000, 32'h0000_8000, 16'h0003, 1'b0);
        send_object(-32769, 16'h1234, 32'h0000_0000, 16'h0004, 1'b0);
        send_object(32769, 16'hFFFF, 32'h0001_0000, 16'h0005, 1'b1);
        send_object(-65536, 16'h0000, 32'h0000_0000, 16'hFFFF, 1'b0);
        send_object(65535, 16'h5555, 32'h0000_1000, 16'h0000, 1'b0);
        send_object(0, 16'h0000, 32'hFFFF_FFFF, 16'hAAAA, 1'b0);
        send_read(13'd511, 3'd7, 1'b1);
    endtask

    task automatic test_redshift_window();
        apply_settings(16, 32, 4, 32'h0000_8000, 32'h0002_0000, 1'b0);
        send_object(0, 16'h0000, 32'h0000_7FFF, 16'h0000, 1'b0);
        send_object(0, 16'h0000, 32'h0000_8000, 16'h0000, 1'b0);
        send_object(0, 16'h0000, 32'h0000_FFFF, 16'h0000, 1'b0);
        send_object(0, 16'h0000, 32'h0001_0000, 16'h0000, 1'b1);
    endtask

    task automatic test_weights();
        apply_settings(16, 32, 8, 32'h0, 32'h0001_0000, 1'b1);
        send_object(0, 16'h4000, 32'h0000_4000, 16'h0000, 1'b0);
        send_object(0, 16'h4000, 32'h0000_4000, 16'h0000, 1'b0);
        send_object(0, 16'h4000, 32'h0000_4000, 16'hFFFF, 1'b0);
        send_read(13'd264, 3'd2, 1'b1);
    endtask

    task automatic test_sizing_extremes();
        apply_settings(127, 255, 15, 32'h0, 32'hFFFF_FFFF, 1'b0);
        send_object(32768, 16'hFFFF, 32'h0000_0000, 16'h0000, 1'b0);
        send_object(-32768, 16'h0000, 32'h0000_0001, 16'h0000, 1'b0);
        send_object(-32768, 16'h0000, 32'h0000_0002, 16'h0000, 1'b0);
        apply_settings(0, 0, 0, 32'h0, 32'h0001_0000, 1'b0);
        send_object(100, 16'h7777, 32'h0000_0100, 16'h0000, 1'b0);
        apply_settings(0, 0, 2, 32'h0, 32'h0, 1'b0);
        cfg_write(CFG_UNMAPPED, $urandom);
        send_object(-20000, 16'hC000, $urandom, 16'h0000, 1'b0);
        send_read('0, '0, 1'b1);
    endtask

    task automatic test_random_phase(input int count, input int sc, input int sp,
                                     input int nb, input logic [Z_W-1:0] origin,
                                     input logic [Z_W-1:0] scale, input bit weights);
        t_catalog_req r, prev;
        logic [63:0]  span;
        logic [15:0]  hit;
        int           pick;
        apply_settings(sc, sp, nb, origin, scale, weights);
        span = (scale == 0) ? 64'hFFFF_FFFF : (64'h1_0000_0000 / scale);
        span = span + span / 8;
        if (span > 64'hFFFF_FFFF)
            span = 64'hFFFF_FFFF;
        for (int i = 0; i < count; i++) begin
            r.op         = ($urandom_range(0, 3) == 0) ? OP_READ : OP_ADD;
            r.cos_theta  = CTH_W'($urandom);
            r.phi_turn   = PHI_W'($urandom);
            r.redshift   = $urandom;
            r.read_pixel = PIXF_W'($urandom);
            r.read_bin   = BINF_W'($urandom);
            r.is_last    = ($urandom_range(0, 15) == 0);
            pick = $urandom_range(0, 9);
            r.weight = (pick == 0) ? '0 : (pick == 1) ? '1 : WT_W'($urandom);
            if (r.op == OP_READ) begin
                if (recent_hits.size() > 0 && $urandom_range(0, 3) != 0) begin
                    hit = recent_hits[$urandom_range(0, recent_hits.size() - 1)];
                    r.read_pixel = hit[15:3];
                    r.read_bin   = hit[2:0];
                end
            end else if (i > 0 && prev.op == OP_ADD && $urandom_range(0, 3) == 0) begin
                // repeat the same pixel and bin back to back
                r.cos_theta = prev.cos_theta;
                r.phi_turn  = prev.phi_turn;
                r.redshift  = prev.redshift;
            end else begin
                pick = $urandom_range(0, 19);
                if (pick < 16)
                    r.cos_theta = CTH_W'(int'($urandom_range(0, 65536)) - 32768);
                else if (pick == 16)
                    r.cos_theta = CTH_W'(-32768);
                else if (pick == 17)
                    r.cos_theta = CTH_W'(32768);
                pick = $urandom_range(0, 19);
                if (pick < 16)
                    r.redshift = origin + $urandom_range(0, 32'(span));
                else if (pick < 18)
                    r.redshift = origin - $urandom_range(1, 4);
            end
            send_req(r);
            prev = r;
        end
    endtask

    // Stall the result side while requests keep coming
    task automatic test_result_backpressure();
        apply_settings(4, 8, 2, 32'h0, 32'h0001_0000, 1'b1);
        idling_enabled = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 60; i++)
            send_object(int'($urandom_range(0, 65536)) - 32768, PHI_W'($urandom),
                        32'($urandom_range(0, 32'hFFFF)), WT_W'($urandom), 1'b0);
        drain_results();
        idling_enabled = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end else if (idling_enabled && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result %0d %s: expected %h, got %h", results_seen, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d arrived with none pending", results_seen);
            end else begin
                oldest_result = pending_results.pop_front();
                note_mismatch("pixel_index", oldest_result.pixel_index, res_ch.pixel_index);
                note_mismatch("red_bin", oldest_result.red_bin, res_ch.red_bin);
                note_mismatch("accepted", oldest_result.accepted, res_ch.accepted);
                note_mismatch("bad_angle", oldest_result.bad_angle, res_ch.bad_angle);
                note_mismatch("bin_count", oldest_result.bin_count, res_ch.bin_count);
                note_mismatch("pixel_count", oldest_result.pixel_count, res_ch.pixel_count);
                note_mismatch("occupied_pixels", oldest_result.occupied_pixels,
                              res_ch.occupied_pixels);
                note_mismatch("last_out", oldest_result.last_out, res_ch.last_out);
            end
            results_seen++;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        obj_ch.valid      = 1'b0;
        obj_ch.op         = OP_ADD;
        obj_ch.cos_theta  = '0;
        obj_ch.phi_turn   = '0;
        obj_ch.redshift   = '0;
        obj_ch.weight     = '0;
        obj_ch.read_pixel = '0;
        obj_ch.read_bin   = '0;
        obj_ch.is_last    = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        res_ch.ready      = 1'b0;
        idling_enabled    = 1'b1;
        hold_request      = 0;
        hold_left         = 0;
        stall_left        = 0;
        mismatches        = 0;
        results_seen      = 0;
        cycles_run        = 0;
        occupied_total    = 0;
        cfg_rows          = SC_W'(16);
        cfg_cols          = SP_W'(32);
        cfg_bins          = NB_W'(8);
        cfg_origin        = '0;
        cfg_scale         = 32'h0001_0000;
        cfg_weighted      = 1'b0;
        foreach (bin_tally[i])
            bin_tally[i] = '0;
        foreach (pixel_tally[i]) begin
            pixel_tally[i] = '0;
            pixel_seen[i]  = 1'b0;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_cleared_store();
        test_angle_edges();
        test_redshift_window();
        test_weights();
        test_sizing_extremes();
        test_result_backpressure();

        test_random_phase(280, 16, 32, 8, 32'h0, 32'h0001_0000, 1'b0);
        test_random_phase(280, 64, 128, 8, 32'h0001_0000, 32'h0000_8000, 1'b1);
        test_random_phase(280, 1, 1, 1, 32'h0, 32'h0001_0000, 1'b1);
        test_random_phase(280, 127, 255, 15, 32'h0, 32'h0002_0000, 1'b0);
        test_random_phase(240, 0, 0, 3, 32'h8000_0000, 32'h0000_0100, 1'b1);
        test_random_phase(240, $urandom_range(1, 64), $urandom_range(1, 128),
                          $urandom_range(1, 8), $urandom, $urandom_range(1, 32'h0004_0000),
                          $urandom_range(0, 1));
        idling_enabled = 1'b0;
        test_random_phase(240, 32, 64, 5, 32'h0000_1000, 32'h0003_0000, 1'b1);

        drain_results();
        if (mismatches == 0)
            $display("sky_redshift_pixel_histogram_test: PASS");
        else
            $display("sky_redshift_pixel_histogram_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
